// ----- rtl/rlrp_pkg.sv -----
package rlrp_pkg;

  // Widths of the result fields as they leave the block.
  localparam int unsigned OUT_VALUE_W   = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned DEF_VALUE_W   = 32;
  localparam int unsigned RESULT_BITS   = STATUS_W + 1 + 4 * OUT_VALUE_W;
  localparam int unsigned RESULT_DATA_W = ((RESULT_BITS + 7) / 8) * 8;

  // Parse status codes.
  localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;

  // Characters the parser looks for.
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] reset_seconds;
    logic [OUT_VALUE_W-1:0] retry_seconds;
    logic [OUT_VALUE_W-1:0] remaining_value;
    logic [OUT_VALUE_W-1:0] limit_value;
    logic                   blocked;
    logic [STATUS_W-1:0]    parse_status;
  } result_t;

endpackage

// ----- rtl/rlrp_parser.sv -----
module rlrp_parser
  import rlrp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output result_t           result_o
);

  typedef enum logic [3:0] {
    PH_COUNT      = 4'd0,
    PH_CRLF_COUNT = 4'd1,
    PH_VERDICT    = 4'd2,
    PH_CRLF_VERD  = 4'd3,
    PH_LIMIT      = 4'd4,
    PH_LF_LIMIT   = 4'd5,
    PH_REMAIN     = 4'd6,
    PH_LF_REMAIN  = 4'd7,
    PH_RETRY      = 4'd8,
    PH_LF_RETRY   = 4'd9,
    PH_RESET      = 4'd10,
    PH_LF_FINAL   = 4'd11
  } phase_e;

  localparam int unsigned WIDE_W = VALUE_WIDTH + 4;

  phase_e                 phase_q, phase_d;
  logic                   blocked_q, blocked_d;
  logic [VALUE_WIDTH-1:0] limit_q, limit_d;
  logic [VALUE_WIDTH-1:0] remain_q, remain_d;
  logic [VALUE_WIDTH-1:0] retry_q, retry_d;
  logic [VALUE_WIDTH-1:0] reset_q, reset_d;

  logic                   is_cr, is_lf, is_colon, is_digit;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] sel_acc;
  logic [WIDE_W-1:0]      wide_sum;
  logic [VALUE_WIDTH-1:0] pushed;
  logic [STATUS_W-1:0]    status;

  assign is_cr    = (byte_i == CH_CR);
  assign is_lf    = (byte_i == CH_LF);
  assign is_colon = (byte_i == CH_COLON);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = 4'(byte_i - CH_ZERO);

  // One shared saturating multiply-by-ten-and-add for the value phases.
  always_comb begin
    case (phase_q)
      PH_LIMIT:  sel_acc = limit_q;
      PH_REMAIN: sel_acc = remain_q;
      PH_RETRY:  sel_acc = retry_q;
      default:   sel_acc = reset_q;
    endcase
  end

  assign wide_sum = (WIDE_W'(sel_acc) << 3) + (WIDE_W'(sel_acc) << 1) + WIDE_W'(digit);
  assign pushed   = (|wide_sum[WIDE_W-1:VALUE_WIDTH]) ? '1 : wide_sum[VALUE_WIDTH-1:0];

  always_comb begin
    phase_d   = phase_q;
    blocked_d = blocked_q;
    limit_d   = limit_q;
    remain_d  = remain_q;
    retry_d   = retry_q;
    reset_d   = reset_q;
    status    = ST_PROGRESS;

    case (phase_q)
      PH_COUNT: begin
        if (byte_i == CH_FIVE) phase_d = PH_CRLF_COUNT;
        else status = ST_ERROR;
      end
      PH_CRLF_COUNT: begin
        if (is_lf) phase_d = PH_VERDICT;
        else if (!is_cr) status = ST_ERROR;
      end
      PH_VERDICT: begin
        if (byte_i == CH_ZERO || byte_i == CH_ONE) begin
          blocked_d = byte_i[0];
          phase_d   = PH_CRLF_VERD;
        end else if (!is_colon) begin
          status = ST_ERROR;
        end
      end
      PH_CRLF_VERD: begin
        if (is_lf) phase_d = PH_LIMIT;
        else if (!is_cr) status = ST_ERROR;
      end
      PH_LIMIT: begin
        if (is_cr) phase_d = PH_LF_LIMIT;
        else if (is_digit) limit_d = pushed;
        else if (!is_colon) status = ST_ERROR;
      end
      PH_LF_LIMIT: begin
        if (is_lf) phase_d = PH_REMAIN;
        else status = ST_ERROR;
      end
      PH_REMAIN: begin
        if (is_cr) phase_d = PH_LF_REMAIN;
        else if (is_digit) remain_d = pushed;
        else if (!is_colon) status = ST_ERROR;
      end
      PH_LF_REMAIN: begin
        if (is_lf) phase_d = PH_RETRY;
        else if (!is_cr) status = ST_ERROR;
      end
      PH_RETRY: begin
        if (is_cr) begin
          phase_d = PH_LF_RETRY;
        end else if (is_colon) begin
          status = ST_PROGRESS;
        end else if (blocked_q) begin
          if (is_digit) retry_d = pushed;
          else status = ST_ERROR;
        end else if (byte_i != CH_DASH && byte_i != CH_ONE) begin
          status = ST_ERROR;
        end
      end
      PH_LF_RETRY: begin
        if (is_lf) phase_d = PH_RESET;
        else status = ST_ERROR;
      end
      PH_RESET: begin
        if (is_cr) phase_d = PH_LF_FINAL;
        else if (is_digit) reset_d = pushed;
        else if (!is_colon) status = ST_ERROR;
      end
      PH_LF_FINAL: begin
        status = is_lf ? ST_DONE : ST_ERROR;
      end
      default: begin
        status = ST_ERROR;
      end
    endcase

    // A finished or malformed reply returns the parser to its start.
    if (status != ST_PROGRESS) begin
      phase_d   = PH_COUNT;
      blocked_d = 1'b0;
      limit_d   = '0;
      remain_d  = '0;
      retry_d   = '0;
      reset_d   = '0;
    end
  end

  always_comb begin
    result_o              = '0;
    result_o.parse_status = status;
    if (status == ST_DONE) begin
      result_o.blocked         = blocked_q;
      result_o.limit_value     = OUT_VALUE_W'(limit_q);
      result_o.remaining_value = OUT_VALUE_W'(remain_q);
      result_o.retry_seconds   = OUT_VALUE_W'(retry_q);
      result_o.reset_seconds   = OUT_VALUE_W'(reset_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_COUNT;
      blocked_q <= 1'b0;
      limit_q   <= '0;
      remain_q  <= '0;
      retry_q   <= '0;
      reset_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      blocked_q <= blocked_d;
      limit_q   <= limit_d;
      remain_q  <= remain_d;
      retry_q   <= retry_d;
      reset_q   <= reset_d;
    end
  end

endmodule

// ----- rtl/rate_limit_reply_parser_top.sv -----
// Rate-limit reply parser: one reply byte in, one status/result transfer out.
// An accepted byte waits in the input register; its parse result is then registered in
// the result register and offered to the sink, and a stalled sink holds both registers.
// Throughput: one byte per cycle unless the sink stalls (single registered parse step).
// Reset (rst_ni low, asynchronous) empties both pipeline registers and returns the
// parser to the start of a reply with all gathered values at zero.
module rate_limit_reply_parser_top
  import rlrp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input byte stream.
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [BYTE_W-1:0]        s_axis_tdata_i,   // [7:0] reply_byte
  // Result stream, one transfer per input byte.
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // From bit 0 up: parse_status[1:0], blocked[2], limit_value[34:3],
  // remaining_value[66:35], retry_seconds[98:67], reset_seconds[130:99],
  // zero fill [135:131].
  output logic [RESULT_DATA_W-1:0] m_axis_tdata_o
);

  // Input register: holds one accepted byte until the result register can
  // take its parse result.
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;

  // Result register.
  logic              out_valid_q;
  result_t           out_data_q;

  logic              out_load;
  logic              step;
  result_t           result;

  // The result register can be loaded when it is empty or being drained this
  // cycle. The byte in the input register is parsed (and the parser state
  // advances) exactly when its result moves into the result register.
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_load;
  assign s_axis_tready_o = !in_valid_q || step;

  rlrp_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = RESULT_DATA_W'(out_data_q);

endmodule

// ----- tb/sv/rate_limit_reply_parser_top_test.sv -----
module rate_limit_reply_parser_top_test;
  import rlrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W = DEF_VALUE_W;
  localparam logic [63:0] VALUE_MAX = (VALUE_W >= 64) ? '1 : ((64'd1 << VALUE_W) - 64'd1);

  // Where the parser stands within one reply.
  typedef enum logic [3:0] {
    PH_COUNT,
    PH_COUNT_SEP,
    PH_VERDICT,
    PH_VERDICT_SEP,
    PH_LIMIT,
    PH_LIMIT_SEP,
    PH_REMAIN,
    PH_REMAIN_SEP,
    PH_RETRY,
    PH_RETRY_SEP,
    PH_RESET,
    PH_FINAL
  } phase_e;

  logic                     clk;
  logic                     rst_n;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [BYTE_W-1:0]        s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [RESULT_DATA_W-1:0] m_axis_tdata;

  // Parser state as the testbench expects it to be.
  phase_e      phase_q;
  logic        blocked_q;
  logic [63:0] value_q [4];   // limit, remaining, retry-after, reset

  result_t         pending_results [$];
  logic [7:0]      reply_bytes [$];
  int unsigned     bytes_sent;
  int unsigned     results_seen;
  int unsigned     fail_count;
  bit              src_steady;
  bit              sink_steady;

  rate_limit_reply_parser_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  function automatic void clear_parser_state();
    phase_q   = PH_COUNT;
    blocked_q = 1'b0;
    foreach (value_q[i]) value_q[i] = '0;
  endfunction

  // One more decimal digit, pinned at the largest value the field can hold.
  function automatic logic [63:0] push_decimal(input logic [63:0] acc, input logic [7:0] digit);
    logic [63:0] d;
    d = {56'd0, digit};
    if (acc > (VALUE_MAX - d) / 64'd10) return VALUE_MAX;
    return acc * 64'd10 + d;
  endfunction

  // Advances the expected parser state by one byte and returns the transfer it should emit.
  function automatic result_t predict_reply_byte(input logic [7:0] c);
    result_t    res;
    logic [1:0] status;
    int         slot;
    res    = '0;
    status = ST_PROGRESS;
    case (phase_q)
      PH_COUNT: begin
        if (c == CH_FIVE) phase_q = PH_COUNT_SEP;
        else status = ST_ERROR;
      end
      PH_COUNT_SEP, PH_VERDICT_SEP, PH_LIMIT_SEP, PH_REMAIN_SEP, PH_RETRY_SEP: begin
        // Extra CRs are forgiven only after the count, the verdict and the remaining count.
        if (c == CH_LF) phase_q = phase_e'(phase_q + 4'd1);
        else if (c != CH_CR || phase_q == PH_LIMIT_SEP || phase_q == PH_RETRY_SEP)
          status = ST_ERROR;
      end
      PH_VERDICT: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          blocked_q = c[0];
          phase_q   = PH_VERDICT_SEP;
        end else if (c != CH_COLON) begin
          status = ST_ERROR;
        end
      end
      PH_LIMIT, PH_REMAIN, PH_RETRY, PH_RESET: begin
        slot = (int'(phase_q) - int'(PH_LIMIT)) / 2;
        if (c == CH_CR) begin
          phase_q = phase_e'(phase_q + 4'd1);
        end else if (phase_q == PH_RETRY && !blocked_q) begin
          // An allowed reply carries "-1" here; it is checked but not gathered.
          if (c != CH_COLON && c != CH_DASH && c != CH_ONE) status = ST_ERROR;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          value_q[slot] = push_decimal(value_q[slot], c - CH_ZERO);
        end else if (c != CH_COLON) begin
          status = ST_ERROR;
        end
      end
      PH_FINAL: status = (c == CH_LF) ? ST_DONE : ST_ERROR;
      default:  status = ST_ERROR;
    endcase
    res.parse_status = status;
    if (status == ST_DONE) begin
      res.blocked         = blocked_q;
      res.limit_value     = value_q[0][OUT_VALUE_W-1:0];
      res.remaining_value = value_q[1][OUT_VALUE_W-1:0];
      res.retry_seconds   = value_q[2][OUT_VALUE_W-1:0];
      res.reset_seconds   = value_q[3][OUT_VALUE_W-1:0];
    end
    if (status != ST_PROGRESS) clear_parser_state();
    return res;
  endfunction

  function automatic void check_result(input logic [RESULT_DATA_W-1:0] data);
    result_t got;
    result_t want;
    got = data[RESULT_BITS-1:0];
    results_seen++;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d arrived with nothing expected: status %0d data %h",
                 results_seen, got.parse_status, data);
    end else begin
      want = pending_results.pop_front();
      if (got.parse_status !== want.parse_status || got.blocked !== want.blocked ||
          got.limit_value !== want.limit_value ||
          got.remaining_value !== want.remaining_value ||
          got.retry_seconds !== want.retry_seconds ||
          got.reset_seconds !== want.reset_seconds ||
          data[RESULT_DATA_W-1:RESULT_BITS] !== '0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result %0d expected: status %0d blocked %0b limit %0d remaining %0d",
                   results_seen, want.parse_status, want.blocked, want.limit_value,
                   want.remaining_value);
          $display("  retry %0d reset %0d fill 0", want.retry_seconds, want.reset_seconds);
          $display("result %0d actual:   status %0d blocked %0b limit %0d remaining %0d",
                   results_seen, got.parse_status, got.blocked, got.limit_value,
                   got.remaining_value);
          $display("  retry %0d reset %0d fill %h", got.retry_seconds, got.reset_seconds,
                   data[RESULT_DATA_W-1:RESULT_BITS]);
        end
      end
    end
  endfunction

  // Sends one reply byte after a random gap (none when src_steady is set) and records what it should produce.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_reply_byte(value));
    bytes_sent++;
  endtask

  task automatic send_reply();
    foreach (reply_bytes[i]) send_byte(reply_bytes[i]);
  endtask

  // Holds the input idle until every outstanding result has been transferred.
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void pick_idle_modes();
    src_steady  = ($urandom_range(0, 4) == 0);
    sink_steady = ($urandom_range(0, 4) == 0);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endfunction

  // CR, now and then one or two extra CRs where stray_ok allows them, then LF.
  function automatic void add_line_end(input bit stray_ok);
    int unsigned extra;
    extra = (stray_ok && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    reply_bytes.push_back(CH_CR);
    repeat (extra) reply_bytes.push_back(CH_CR);
    reply_bytes.push_back(CH_LF);
  endfunction

  // A decimal element: empty, right at or just past the field maximum, long enough to
  // saturate, or short; stray colons are mixed in now and then.
  function automatic void add_number();
    int unsigned mode;
    int unsigned n;
    if ($urandom_range(0, 7) != 0) reply_bytes.push_back(CH_COLON);
    mode = $urandom_range(0, 9);
    if (mode == 1) begin
      add_text("4294967295");
    end else if (mode == 2) begin
      add_text("4294967296");
    end else begin
      n = (mode == 0) ? 0 : (mode == 3) ? $urandom_range(10, 13) : $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) reply_bytes.push_back(CH_COLON);
        reply_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
  endfunction

  // Retry-after text of an allowed reply: mostly "-1", sometimes other runs of '-' and '1'.
  function automatic void add_retry_marks();
    if ($urandom_range(0, 7) != 0) reply_bytes.push_back(CH_COLON);
    if ($urandom_range(0, 3) != 0) begin
      reply_bytes.push_back(CH_DASH);
      reply_bytes.push_back(CH_ONE);
    end else begin
      repeat ($urandom_range(0, 3))
        reply_bytes.push_back($urandom_range(0, 1) ? CH_DASH : CH_ONE);
    end
  endfunction

  function automatic void build_reply(input bit blocked);
    reply_bytes.delete();
    reply_bytes.push_back(CH_FIVE);
    add_line_end(1'b1);
    repeat ($urandom_range(0, 3) == 0 ? 2 : 1) reply_bytes.push_back(CH_COLON);
    reply_bytes.push_back(blocked ? CH_ONE : CH_ZERO);
    add_line_end(1'b1);
    add_number();
    add_line_end(1'b0);
    add_number();
    add_line_end(1'b1);
    if (blocked) add_number();
    else add_retry_marks();
    add_line_end(1'b0);
    add_number();
    add_line_end(1'b0);
  endfunction

  // Bytes that sit on or next to a decision the parser makes.
  function automatic logic [7:0] tricky_byte();
    case ($urandom_range(0, 10))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_COLON;
      3:       return CH_DASH;
      4:       return CH_ZERO;
      5:       return CH_ONE;
      6:       return CH_FIVE;
      7:       return CH_NINE;
      8:       return CH_ZERO - 8'd1;
      9:       return CH_NINE + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_extreme_bytes();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  // Blocked verdict with stray CRs after the count, verdict and remaining count,
  // doubled colons, and empty limit and reset elements.
  task automatic test_blocked_reply_with_tolerances();
    reply_bytes.delete();
    add_text("5\015\015\n::1\015\015\n:\015\n7\015\015\n:3\015\n\015\n");
    send_reply();
  endtask

  task automatic test_allowed_replies(input int unsigned byte_goal);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      pick_idle_modes();
      build_reply(1'b0);
      send_reply();
    end
  endtask

  task automatic test_blocked_replies(input int unsigned byte_goal);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      pick_idle_modes();
      build_reply(1'b1);
      send_reply();
    end
  endtask

  // Well-formed replies with one byte replaced, one inserted, or the tail cut off.
  task automatic test_broken_replies(input int unsigned byte_goal);
    int unsigned start;
    int unsigned pos;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      pick_idle_modes();
      build_reply($urandom_range(0, 1));
      pos = $urandom_range(0, reply_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: reply_bytes[pos] = tricky_byte();
        1: reply_bytes.insert(pos, tricky_byte());
        default: while (reply_bytes.size() > pos + 1) void'(reply_bytes.pop_back());
      endcase
      send_reply();
    end
  endtask

  task automatic test_byte_noise(input int unsigned byte_goal);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      if ((bytes_sent - start) % 20 == 0) pick_idle_modes();
      send_byte($urandom_range(0, 3) == 0 ? tricky_byte() : 8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: stalls a random number of cycles before each transfer, unless sink_steady is set.
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
    end
  end

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_n         = 1'b0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    bytes_sent    = 0;
    results_seen  = 0;
    fail_count    = 0;
    clear_parser_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extreme_bytes();
    test_blocked_reply_with_tolerances();
    wait_for_results();
    test_allowed_replies(450);
    test_blocked_replies(550);
    wait_for_results();
    test_broken_replies(350);
    test_byte_noise(200);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
